>>> rtl/mmstk_pkg.sv
// ----------------------------------------------------------------------------
// mmstk_pkg: shared types and constants of the min/max stack
// Holds the per-level entry type, the shift command that runs along the
// chain of cells, operation codes and the packed stream widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mmstk_pkg;

    // Width of one held value.
    localparam int unsigned VAL_W = 32;
    // Width of the running sum.
    localparam int unsigned SUM_W = 40;
    // Width of the reported entry count.
    localparam int unsigned CNT_OUT_W = 9;

    // Stream widths: input value in tdata, operation in tuser.
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 1;
    // Result fields packed in tdata and padded to whole bytes.
    localparam int unsigned M_TDATA_W = 152;
    localparam int unsigned M_PAD_W   = M_TDATA_W - (3 * VAL_W + CNT_OUT_W + SUM_W);
    localparam int unsigned M_TUSER_W = 2;

    // Operation codes carried in s_tuser.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // One stack level: the value and the min/max of this level and all below.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] lmin;
        logic signed [VAL_W-1:0] lmax;
    } entry_t;

    // Shift command broadcast to every cell.
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

endpackage : mmstk_pkg

`default_nettype wire

>>> rtl/mmstk_cell.sv
// ----------------------------------------------------------------------------
// mmstk_cell: one level of the shifting stack
// Holds one entry. On a push it takes the entry of the level above, on a
// pop the entry of the level below, otherwise it keeps its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mmstk_cell (
    input  wire                   aclk,
    input  wire mmstk_pkg::shift_t shift,
    input  wire mmstk_pkg::entry_t from_above,
    input  wire mmstk_pkg::entry_t from_below,
    output mmstk_pkg::entry_t     entry
);

    mmstk_pkg::entry_t entry_reg;
    mmstk_pkg::entry_t entry_next;

    // Select the neighbor to take from; push and pop never come together.
    always_comb begin
        if (shift.push) begin
            entry_next = from_above;
        end else if (shift.pop) begin
            entry_next = from_below;
        end else begin
            entry_next = entry_reg;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule : mmstk_cell

`default_nettype wire

>>> rtl/mmstk_ctrl.sv
// ----------------------------------------------------------------------------
// mmstk_ctrl: stack control, running statistics and result register
// Tracks the fill count and exact sum, builds the entry for a push from the
// cached top level, drives the shift command and registers each result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mmstk_ctrl #(
    parameter int unsigned STACK_DEPTH = 256
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // Input stream
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [mmstk_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire  [mmstk_pkg::S_TUSER_W-1:0]       s_tuser,
    // Result stream
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [mmstk_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [mmstk_pkg::M_TUSER_W-1:0]       m_tuser,
    // Chain interface
    input  wire mmstk_pkg::entry_t                top_entry,
    input  wire mmstk_pkg::entry_t                second_entry,
    output mmstk_pkg::entry_t                     new_entry,
    output mmstk_pkg::shift_t                     shift
);

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]                         count_reg;
    logic [CNT_W-1:0]                         count_next;
    logic signed [mmstk_pkg::SUM_W-1:0]       sum_reg;
    logic signed [mmstk_pkg::SUM_W-1:0]       sum_next;
    logic                                     m_valid_reg;
    logic                                     m_valid_next;
    logic [mmstk_pkg::M_TDATA_W-1:0]          m_data_reg;
    logic [mmstk_pkg::M_TDATA_W-1:0]          m_data_next;
    logic [mmstk_pkg::M_TUSER_W-1:0]          m_user_reg;
    logic [mmstk_pkg::M_TUSER_W-1:0]          m_user_next;

    logic                                     accept;
    logic                                     is_pop;
    logic                                     empty;
    logic                                     full;
    logic                                     do_push;
    logic                                     do_pop;
    logic signed [mmstk_pkg::VAL_W-1:0]       push_val;
    logic signed [mmstk_pkg::VAL_W-1:0]       popped;
    logic signed [mmstk_pkg::SUM_W-1:0]       delta;
    mmstk_pkg::entry_t                        after_top;
    logic signed [mmstk_pkg::VAL_W-1:0]       cmax;
    logic signed [mmstk_pkg::VAL_W-1:0]       cmin;
    logic [CNT_W+mmstk_pkg::CNT_OUT_W-1:0]    cnt_wide;

    // The input side is free whenever the result register is empty or draining.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_pop   = (s_tuser[0] == mmstk_pkg::OP_POP);
    assign push_val = $signed(s_tdata[mmstk_pkg::VAL_W-1:0]);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign do_push  = accept && !is_pop && !full;
    assign do_pop   = accept && is_pop && !empty;

    assign shift.push = do_push;
    assign shift.pop  = do_pop;

    // New top level: min/max folded with the current top when one exists.
    always_comb begin
        new_entry.value = push_val;
        new_entry.lmin  = push_val;
        new_entry.lmax  = push_val;
        if (!empty) begin
            if ($signed(top_entry.lmin) < push_val) begin
                new_entry.lmin = top_entry.lmin;
            end
            if ($signed(top_entry.lmax) > push_val) begin
                new_entry.lmax = top_entry.lmax;
            end
        end
    end

    // Count and sum update.
    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        delta      = '0;
        if (do_push) begin
            delta      = {{(mmstk_pkg::SUM_W-mmstk_pkg::VAL_W){push_val[mmstk_pkg::VAL_W-1]}},
                          push_val};
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + delta;
        end else if (do_pop) begin
            delta      = {{(mmstk_pkg::SUM_W-mmstk_pkg::VAL_W){top_entry.value[mmstk_pkg::VAL_W-1]}},
                          top_entry.value};
            count_next = count_reg - CNT_W'(1);
            sum_next   = sum_reg - delta;
        end
    end

    // Result fields as seen after the operation.
    always_comb begin
        if (!is_pop) begin
            popped = '0;
        end else if (empty) begin
            popped = '1;
        end else begin
            popped = top_entry.value;
        end

        if (do_push) begin
            after_top = new_entry;
        end else if (do_pop) begin
            after_top = second_entry;
        end else begin
            after_top = top_entry;
        end

        if (count_next == '0) begin
            cmax = '0;
            cmin = '0;
        end else begin
            cmax = after_top.lmax;
            cmin = after_top.lmin;
        end

        cnt_wide = {{mmstk_pkg::CNT_OUT_W{1'b0}}, count_next};
    end

    // Output register next values.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {{mmstk_pkg::M_PAD_W{1'b0}}, cmin, cmax, sum_next,
                            cnt_wide[mmstk_pkg::CNT_OUT_W-1:0], popped};
            m_user_next  = {!is_pop && full, is_pop && empty};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("fill count above stack depth");

    // An empty stack always sums to zero.
    a_empty_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("nonzero sum on empty stack");

    // A taken push grows the stack by one level.
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the stack");

    // A taken pop shrinks the stack by one level.
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not shrink the stack");
`endif

endmodule : mmstk_ctrl

`default_nettype wire

>>> rtl/stack_with_sum_min_max.sv
// ----------------------------------------------------------------------------
// stack_with_sum_min_max: bounded stack with exact sum, minimum and maximum
// A row of shifting cells holds the stack, top at cell 0; each level keeps
// the min and max of itself and everything below it.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat content
//  s_*       in         tdata: push value; tuser: operation (push / pop)
//  m_*       out        tdata: popped value, count, sum, max, min;
//                       tuser: pop on empty, push dropped
//
//  The chain shifts all levels at once and the control reads only the two top
//  cells, so one beat is taken per cycle whenever s_tready is high.
//  A result appears on m_* in the cycle after its input beat is taken.
//  s_tready stays high while the result register is empty or being drained.
//  aresetn (synchronous, active low) empties the stack and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_sum_min_max #(
    parameter int unsigned STACK_DEPTH = 256
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // Input stream
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [mmstk_pkg::S_TDATA_W-1:0]       s_tdata,  // [31:0] push_value
    input  wire  [mmstk_pkg::S_TUSER_W-1:0]       s_tuser,  // [0] mode
    // Result stream
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // [31:0] popped_value, [40:32] entry_count, [80:41] content_sum,
    // [112:81] content_max, [144:113] content_min, [151:145] zero
    output logic [mmstk_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [mmstk_pkg::M_TUSER_W-1:0]       m_tuser   // [0] pop_on_empty, [1] push_dropped
);

    mmstk_pkg::entry_t cells [STACK_DEPTH];
    mmstk_pkg::entry_t new_entry;
    mmstk_pkg::shift_t shift;

    // Control, statistics and result register.
    mmstk_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .top_entry    (cells[0]),
        .second_entry (cells[1]),
        .new_entry    (new_entry),
        .shift        (shift)
    );

    // Chain of levels: a push moves every entry one cell deeper, a pop one
    // cell up. The bottom cell refills from itself on a pop; that level is
    // beyond the fill count then and never read.
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        mmstk_pkg::entry_t above;
        mmstk_pkg::entry_t below;

        if (i == 0) begin : g_top
            assign above = new_entry;
        end else begin : g_mid
            assign above = cells[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_bottom
            assign below = cells[i];
        end else begin : g_up
            assign below = cells[i+1];
        end

        mmstk_cell u_cell (
            .aclk       (aclk),
            .shift      (shift),
            .from_above (above),
            .from_below (below),
            .entry      (cells[i])
        );
    end

endmodule : stack_with_sum_min_max

`default_nettype wire

>>> tb/stack_with_sum_min_max_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_with_sum_min_max_tb: self-checking bench for the min/max stack
// Every accepted input beat goes through a local stack model that keeps
// its own levels, running sum and per-level min/max. The resulting record
// is queued and compared field by field with each result beat. A short
// directed run covers the empty stack, value extremes and sign cases. Long
// fill and drain phases then reach the full stack with the largest and
// smallest sums. Random segments with push or pop bias follow. Both stream
// sides idle at random, and there is one long receiver hold-off.
// ----------------------------------------------------------------------------

module stack_with_sum_min_max_tb;

    localparam int unsigned DEPTH      = 256;
    localparam int unsigned RESET_CYC  = 7;
    localparam int unsigned DIR_N      = 23;
    localparam int unsigned RAND_ITEMS = 1880;
    localparam int unsigned PAUSE_AT   = 1200;
    localparam int unsigned HOLD_AT    = 300;
    localparam int unsigned HOLD_CYC   = 80;
    localparam int unsigned MAX_REPORTS = 50;
    localparam longint     LIMIT_NS   = 2_000_000;

    // One result record, in the order the fields are checked.
    typedef struct packed {
        logic signed [mmstk_pkg::VAL_W-1:0]     popped;
        logic                                   empty_pop;
        logic                                   full_drop;
        logic [mmstk_pkg::CNT_OUT_W-1:0]        count;
        logic signed [mmstk_pkg::SUM_W-1:0]     content_sum;
        logic signed [mmstk_pkg::VAL_W-1:0]     cmax;
        logic signed [mmstk_pkg::VAL_W-1:0]     cmin;
    } stack_result_t;

    // One directed beat; typed_in marks a row whose result is written out here.
    typedef struct packed {
        logic                           op;
        logic [mmstk_pkg::VAL_W-1:0]    val;
        logic                           typed_in;
        stack_result_t                  res;
    } seq_row_t;

    typedef enum int unsigned {VAL_ANY, VAL_NARROW, VAL_EDGE, VAL_CONST} val_style_e;
    typedef enum int unsigned {SINK_OPEN, SINK_RANDOM, SINK_SPARSE} sink_style_e;

    localparam stack_result_t NO_RES = '0;

    // Directed beats: empty stack, both value extremes, sign cases, drain to empty.
    localparam seq_row_t DIRECTED_SEQ [DIR_N] = '{
        '{mmstk_pkg::OP_POP,  32'h0000_0000, 1'b1,
          '{-32'sd1, 1'b1, 1'b0, 9'd0, 40'sd0, 32'sd0, 32'sd0}},
        '{mmstk_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b1,
          '{32'sd0, 1'b0, 1'b0, 9'd1, 40'sd2147483647, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
        '{mmstk_pkg::OP_PUSH, 32'h8000_0000, 1'b1,
          '{32'sd0, 1'b0, 1'b0, 9'd2, -40'sd1, 32'h7FFF_FFFF, 32'h8000_0000}},
        '{mmstk_pkg::OP_POP,  32'h1234_5678, 1'b1,
          '{32'h8000_0000, 1'b0, 1'b0, 9'd1, 40'sd2147483647, 32'h7FFF_FFFF,
            32'h7FFF_FFFF}},
        '{mmstk_pkg::OP_POP,  32'hFFFF_FFFF, 1'b1,
          '{32'h7FFF_FFFF, 1'b0, 1'b0, 9'd0, 40'sd0, 32'sd0, 32'sd0}},
        '{mmstk_pkg::OP_POP,  32'h8000_0000, 1'b1,
          '{-32'sd1, 1'b1, 1'b0, 9'd0, 40'sd0, 32'sd0, 32'sd0}},
        '{mmstk_pkg::OP_PUSH, 32'h0000_0000, 1'b1,
          '{32'sd0, 1'b0, 1'b0, 9'd1, 40'sd0, 32'sd0, 32'sd0}},
        '{mmstk_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b1,
          '{32'sd0, 1'b0, 1'b0, 9'd2, -40'sd1, 32'sd0, -32'sd1}},
        '{mmstk_pkg::OP_PUSH, 32'h0000_0001, 1'b1,
          '{32'sd0, 1'b0, 1'b0, 9'd3, 40'sd0, 32'sd1, -32'sd1}},
        '{mmstk_pkg::OP_PUSH, 32'h8000_0000, 1'b0, NO_RES},
        '{mmstk_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b0, NO_RES},
        '{mmstk_pkg::OP_PUSH, 32'hAAAA_AAAA, 1'b0, NO_RES},
        '{mmstk_pkg::OP_PUSH, 32'h5555_5555, 1'b0, NO_RES},
        '{mmstk_pkg::OP_POP,  32'hFFFF_FFFF, 1'b0, NO_RES},
        '{mmstk_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_RES},
        '{mmstk_pkg::OP_PUSH, 32'hFFFF_FFFE, 1'b0, NO_RES},
        '{mmstk_pkg::OP_POP,  32'h5555_5555, 1'b0, NO_RES},
        '{mmstk_pkg::OP_POP,  32'hAAAA_AAAA, 1'b0, NO_RES},
        '{mmstk_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_RES},
        '{mmstk_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_RES},
        '{mmstk_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_RES},
        '{mmstk_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_RES},
        '{mmstk_pkg::OP_POP,  32'hFFFF_FFFF, 1'b0, NO_RES}
    };

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mmstk_pkg::S_TDATA_W-1:0] s_tdata  = '0;  // [31:0] push_value
    logic [mmstk_pkg::S_TUSER_W-1:0] s_tuser  = '0;  // [0] mode
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [31:0] popped_value, [40:32] entry_count, [80:41] content_sum,
    // [112:81] content_max, [144:113] content_min, [151:145] zero
    logic [mmstk_pkg::M_TDATA_W-1:0] m_tdata;
    logic [mmstk_pkg::M_TUSER_W-1:0] m_tuser;  // [0] pop_on_empty, [1] push_dropped

    // Local copy of the stack: values and per-level min/max.
    logic signed [mmstk_pkg::VAL_W-1:0] held_val [DEPTH];
    logic signed [mmstk_pkg::VAL_W-1:0] level_min [DEPTH];
    logic signed [mmstk_pkg::VAL_W-1:0] level_max [DEPTH];
    int unsigned                        fill_now = 0;
    logic signed [mmstk_pkg::SUM_W-1:0] sum_now  = '0;

    stack_result_t expect_q [$];

    int unsigned err_cnt     = 0;
    int unsigned n_beats     = 0;
    int unsigned n_push      = 0;
    int unsigned n_pop       = 0;
    int unsigned n_empty_pop = 0;
    int unsigned n_drop      = 0;
    int unsigned n_results   = 0;
    int unsigned peak_fill   = 0;
    int unsigned burst_left  = 0;

    stack_with_sum_min_max #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock: 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Apply one operation to the local stack and return the record it yields.
    function automatic stack_result_t stack_apply(logic op,
                                                  logic signed [mmstk_pkg::VAL_W-1:0] val);
        stack_result_t                      r;
        logic signed [mmstk_pkg::VAL_W-1:0] lo;
        logic signed [mmstk_pkg::VAL_W-1:0] hi;
        r  = '0;
        lo = val;
        hi = val;
        if (op == mmstk_pkg::OP_POP) begin
            if (fill_now == 0) begin
                r.popped    = -32'sd1;
                r.empty_pop = 1'b1;
            end else begin
                fill_now--;
                r.popped = held_val[fill_now];
                sum_now  = sum_now -
                           {{(mmstk_pkg::SUM_W-mmstk_pkg::VAL_W){r.popped[mmstk_pkg::VAL_W-1]}},
                            r.popped};
            end
        end else if (fill_now >= DEPTH) begin
            r.full_drop = 1'b1;
        end else begin
            if (fill_now > 0) begin
                if (level_min[fill_now-1] < lo) lo = level_min[fill_now-1];
                if (level_max[fill_now-1] > hi) hi = level_max[fill_now-1];
            end
            held_val[fill_now]  = val;
            level_min[fill_now] = lo;
            level_max[fill_now] = hi;
            fill_now++;
            sum_now = sum_now +
                      {{(mmstk_pkg::SUM_W-mmstk_pkg::VAL_W){val[mmstk_pkg::VAL_W-1]}}, val};
        end
        if (fill_now > 0) begin
            r.cmax = level_max[fill_now-1];
            r.cmin = level_min[fill_now-1];
        end
        r.count       = (mmstk_pkg::CNT_OUT_W)'(fill_now);
        r.content_sum = sum_now;
        return r;
    endfunction

    function automatic logic [mmstk_pkg::VAL_W-1:0] pick_value(val_style_e vs,
                                                               logic [mmstk_pkg::VAL_W-1:0] c);
        case (vs)
            VAL_ANY:    return $urandom;
            VAL_NARROW: return (mmstk_pkg::VAL_W)'(int'($urandom_range(0, 32)) - 16);
            VAL_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default:    return c;
        endcase
    endfunction

    function automatic void check_field(string fname, logic signed [mmstk_pkg::SUM_W-1:0] want,
                                        logic signed [mmstk_pkg::SUM_W-1:0] got);
        if (got !== want) begin
            if (err_cnt < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, fname, want, got);
            err_cnt++;
        end
    endfunction

    // Offer one beat until taken, queue its expected result, then maybe idle.
    task automatic send_beat(input logic op, input logic [mmstk_pkg::VAL_W-1:0] val,
                             input logic typed_in, input stack_result_t typed_res);
        stack_result_t pred;
        int unsigned   gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        pred = stack_apply(op, val);
        expect_q.insert(expect_q.size(), typed_in ? typed_res : pred);
        n_beats++;
        if (op == mmstk_pkg::OP_POP) n_pop++;
        else n_push++;
        if (pred.empty_pop) n_empty_pop++;
        if (pred.full_drop) n_drop++;
        if (fill_now > peak_fill) peak_fill = fill_now;
        // Bursts of random length, with the odd long run and random gaps between.
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stimulus: reset, directed beats, then biased random segments.
    initial begin : stim_source
        seq_row_t                    row;
        val_style_e                  vstyle;
        logic [mmstk_pkg::VAL_W-1:0] seg_const;
        logic [mmstk_pkg::VAL_W-1:0] v;
        logic                        op;
        int unsigned                 seg_left;
        int unsigned                 seg_no;
        int unsigned                 push_pct;
        vstyle    = VAL_ANY;
        seg_const = '0;
        seg_left  = 0;
        seg_no    = 0;
        push_pct  = 50;
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            row = DIRECTED_SEQ[i];
            send_beat(row.op, row.val, row.typed_in, row.res);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // First fill with the largest value, drain past empty, fill with
            // the smallest value; after that pick push bias and values at random.
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 150);
                case (seg_no)
                    0: begin
                        push_pct  = 100;
                        vstyle    = VAL_CONST;
                        seg_const = 32'h7FFF_FFFF;
                        seg_left  = DEPTH + 6;
                    end
                    1: begin
                        push_pct = 0;
                        seg_left = DEPTH + 6;
                    end
                    2: begin
                        push_pct  = 100;
                        vstyle    = VAL_CONST;
                        seg_const = 32'h8000_0000;
                        seg_left  = DEPTH + 6;
                    end
                    default: begin
                        case ($urandom_range(0, 2))
                            0:       push_pct = 85;
                            1:       push_pct = 15;
                            default: push_pct = 50;
                        endcase
                        vstyle    = val_style_e'($urandom_range(0, 3));
                        seg_const = $urandom;
                    end
                endcase
                seg_no++;
            end
            seg_left--;

            // Once, let every outstanding result drain before going on.
            if (n == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                while (expect_q.size() != 0) @(posedge aclk);
            end

            op = ($urandom_range(0, 99) < push_pct) ? mmstk_pkg::OP_PUSH : mmstk_pkg::OP_POP;
            v  = (op == mmstk_pkg::OP_PUSH) ? pick_value(vstyle, seg_const) : $urandom;
            send_beat(op, v, 1'b0, NO_RES);
        end

        // Wait for the last results, then keep watching for stray beats.
        s_tvalid <= 1'b0;
        while (expect_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d stack operations: %0d pushes, %0d pops, %0d pops on empty,",
                 n_beats, n_push, n_pop, n_empty_pop);
        $display("%0d pushes dropped at full; deepest fill %0d of %0d; %0d results checked.",
                 n_drop, peak_fill, DEPTH, n_results);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Result side: stall styles of its own, plus one long hold-off.
    initial begin : result_sink
        sink_style_e style;
        int unsigned style_left;
        int unsigned hold_left;
        int unsigned tick;
        bit          hold_done;
        style      = SINK_OPEN;
        style_left = 0;
        hold_left  = 0;
        tick       = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && n_beats >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYC;
                m_tready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style      = sink_style_e'($urandom_range(0, 2));
                    style_left = $urandom_range(16, 120);
                end
                style_left--;
                case (style)
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_RANDOM: m_tready <= ($urandom_range(0, 99) < 60);
                    default:     m_tready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    // Compare each result beat with the oldest expected record.
    always @(posedge aclk) begin : result_check
        stack_result_t got;
        stack_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.popped      = m_tdata[31:0];
            got.count       = m_tdata[40:32];
            got.content_sum = m_tdata[80:41];
            got.cmax        = m_tdata[112:81];
            got.cmin        = m_tdata[144:113];
            got.empty_pop   = m_tuser[0];
            got.full_drop   = m_tuser[1];
            if (expect_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, %s %0d",
                         $time, "actual count", got.count);
                err_cnt++;
            end else begin
                want = expect_q.pop_front();
                n_results++;
                check_field("popped_value", want.popped, got.popped);
                check_field("pop_on_empty", want.empty_pop, got.empty_pop);
                check_field("push_dropped", want.full_drop, got.full_drop);
                check_field("entry_count", want.count, got.count);
                check_field("content_sum", want.content_sum, got.content_sum);
                check_field("content_max", want.cmax, got.cmax);
                check_field("content_min", want.cmin, got.cmin);
            end
        end
    end

    // Hard stop in case the handshakes hang.
    initial begin : watchdog
        #(LIMIT_NS);
        $display("Run did not finish within %0d ns.", LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
